/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, operation and status codes, and the control bundle that the
// list sequencer hands to every storage cell.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int OpW     = 3;
  localparam int PosW    = 3;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int TotalW  = 4;

  // positions are 3 bits wide, so only the first cells can be addressed
  localparam int PosSpan = 2 ** PosW;

  typedef logic [OpW-1:0]            op_t;
  typedef logic [PosW-1:0]           pos_t;
  typedef logic signed [DataW-1:0]   word_t;
  typedef logic [StatusW-1:0]        status_t;

  localparam op_t OP_CLEAR    = 3'd0;
  localparam op_t OP_APPEND   = 3'd1;
  localparam op_t OP_INSERT   = 3'd2;
  localparam op_t OP_RETRIEVE = 3'd3;
  localparam op_t OP_REPLACE  = 3'd4;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;
  localparam status_t STATUS_RANGE = 2'd3;

  // broadcast to all cells; commit is high for the single cycle in which an
  // accepted, error-free transaction updates the store
  typedef struct packed {
    logic  commit;
    op_t   op;
    pos_t  pos;
    word_t value;
  } ple_ctl_t;

endpackage : ple_pkg
`default_nettype wire

/* rtl/ple_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell
// One list entry. Holds its word, takes the left neighbour's word on an
// insert, and carries the read bus one step along the chain each cycle.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int Idx = 0,
  parameter int CntW = 4
) (
  input  wire                  clk,
  input  ple_pkg::ple_ctl_t    ctl,
  input  wire [CntW-1:0]       cnt,
  input  ple_pkg::word_t       left_word,
  input  ple_pkg::word_t       bus_in,
  output ple_pkg::word_t       word_out,
  output ple_pkg::word_t       bus_out
);

  ple_pkg::word_t word_r, word_nxt;
  ple_pkg::word_t bus_r, bus_nxt;
  logic           at_pos;
  logic           above_pos;
  logic           at_cnt;

  assign at_pos    = (Idx < ple_pkg::PosSpan) &&
                     (ctl.pos == ple_pkg::PosW'(Idx));
  assign above_pos = (Idx > int'(ctl.pos));
  assign at_cnt    = (cnt == CntW'(Idx));

  always_comb begin
    word_nxt = word_r;
    if (ctl.commit) begin
      unique case (ctl.op)
        ple_pkg::OP_APPEND: begin
          if (at_cnt) word_nxt = ctl.value;
        end
        ple_pkg::OP_INSERT: begin
          // cells above the count also shift, harmless as they are unread
          if (at_pos) word_nxt = ctl.value;
          else if (above_pos) word_nxt = left_word;
        end
        ple_pkg::OP_REPLACE: begin
          if (at_pos) word_nxt = ctl.value;
        end
        default: word_nxt = word_r;
      endcase
    end
  end

  // read bus picks up this cell's word when it is the addressed one
  assign bus_nxt = at_pos ? word_r : bus_in;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    bus_r  <= bus_nxt;
  end

  assign word_out = word_r;
  assign bus_out  = bus_r;

endmodule : ple_cell
`default_nettype wire

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed words: clear, append, insert, retrieve and
// replace, one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel carries operation, position and value; out_* channel
//   returns status, read_value, item_total, empty_flag and full_flag.
//   Both sides use valid/stall; a transaction moves when valid is high and
//   stall is low.
//   Entries live in a chain of CAPACITY cells. Every transaction sweeps the
//   read bus through the whole chain, one cell per cycle, and then commits.
//   One transaction is in flight at a time: the input stalls from
//   acceptance until the commit.
//   While the receiver stalls, the finished result waits in the output
//   register; a new transaction may be accepted meanwhile and holds at its
//   commit step until the output register is free.
//   Reset empties the list and drops any pending result; stored words are
//   left as they are and are never read before being written again.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [ple_pkg::OpW-1:0]               in_operation,
  input  wire [ple_pkg::PosW-1:0]              in_position,
  input  wire signed [ple_pkg::DataW-1:0]      in_value,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [ple_pkg::StatusW-1:0]          out_status,
  output logic signed [ple_pkg::DataW-1:0]     out_read_value,
  output logic [ple_pkg::TotalW-1:0]           out_item_total,
  output logic                                 out_empty_flag,
  output logic                                 out_full_flag
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int SwW   = $clog2(CAPACITY);
  localparam int CmpW  = (CntW > ple_pkg::PosW) ? CntW : ple_pkg::PosW;
  localparam int ExtW  = (CntW > ple_pkg::TotalW) ? CntW : ple_pkg::TotalW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [SwW-1:0]       sweep_r, sweep_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  ple_pkg::op_t         op_r, op_nxt;
  ple_pkg::pos_t        pos_r, pos_nxt;
  ple_pkg::word_t       value_r, value_nxt;

  logic                 out_valid_r, out_valid_nxt;
  ple_pkg::status_t     out_status_r, out_status_nxt;
  ple_pkg::word_t       out_read_r, out_read_nxt;
  logic [ple_pkg::TotalW-1:0] out_total_r, out_total_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic                 out_full_r, out_full_nxt;

  logic                 in_accept;
  logic                 commit;
  logic                 is_full;
  logic                 is_empty;
  logic                 in_range;
  ple_pkg::status_t     status;
  logic                 ok;
  logic [CntW-1:0]      cnt_after;
  logic [ExtW-1:0]      cnt_ext;
  ple_pkg::ple_ctl_t    ctl;

  ple_pkg::word_t       word_w [CAPACITY];
  ple_pkg::word_t       bus_w  [CAPACITY];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // checks against the count before this transaction
  assign is_full  = (count_r == CntW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign in_range = (CmpW'(pos_r) < CmpW'(count_r));

  always_comb begin
    status = ple_pkg::STATUS_OK;
    unique case (op_r)
      ple_pkg::OP_APPEND: begin
        if (is_full) status = ple_pkg::STATUS_FULL;
      end
      ple_pkg::OP_INSERT: begin
        priority if (is_full)   status = ple_pkg::STATUS_FULL;
        else if (is_empty)      status = ple_pkg::STATUS_EMPTY;
        else if (!in_range)     status = ple_pkg::STATUS_RANGE;
        else                    status = ple_pkg::STATUS_OK;
      end
      ple_pkg::OP_RETRIEVE, ple_pkg::OP_REPLACE: begin
        priority if (is_empty)  status = ple_pkg::STATUS_EMPTY;
        else if (!in_range)     status = ple_pkg::STATUS_RANGE;
        else                    status = ple_pkg::STATUS_OK;
      end
      default: status = ple_pkg::STATUS_OK;
    endcase
  end

  assign ok = (status == ple_pkg::STATUS_OK);

  always_comb begin
    cnt_after = count_r;
    unique case (op_r)
      ple_pkg::OP_CLEAR:  cnt_after = '0;
      ple_pkg::OP_APPEND,
      ple_pkg::OP_INSERT: begin
        if (ok) cnt_after = count_r + CntW'(1);
      end
      default: cnt_after = count_r;
    endcase
  end

  assign cnt_ext = ExtW'(cnt_after);

  assign ctl.commit = commit && ok;
  assign ctl.op     = op_r;
  assign ctl.pos    = pos_r;
  assign ctl.value  = value_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    count_nxt = count_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    value_nxt = value_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_operation;
          pos_nxt   = in_position;
          value_nxt = in_value;
          sweep_nxt = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // read bus steps one cell along the chain per cycle until it reaches the end
        if (sweep_r == SwW'(CAPACITY - 1)) begin
          state_nxt = S_DONE;
        end else begin
          sweep_nxt = sweep_r + SwW'(1);
        end
      end
      S_DONE: begin
        if (commit) begin
          count_nxt = cnt_after;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_total_nxt  = out_total_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    if (commit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status;
      out_read_nxt   = (ok && (op_r == ple_pkg::OP_RETRIEVE ||
                               op_r == ple_pkg::OP_REPLACE))
                       ? bus_w[CAPACITY-1] : '0;
      out_total_nxt  = cnt_ext[ple_pkg::TotalW-1:0];
      out_empty_nxt  = (cnt_after == '0);
      out_full_nxt   = (cnt_after == CntW'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sweep_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_total_r  <= out_total_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ple_pkg::word_t left_w;
    ple_pkg::word_t bus_in_w;
    if (i == 0) begin : g_first
      assign left_w   = '0;
      assign bus_in_w = '0;
    end else begin : g_rest
      assign left_w   = word_w[i-1];
      assign bus_in_w = bus_w[i-1];
    end
    ple_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cnt       (count_r),
      .left_word (left_w),
      .bus_in    (bus_in_w),
      .word_out  (word_w[i]),
      .bus_out   (bus_w[i])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_r;
  assign out_item_total = out_total_r;
  assign out_empty_flag = out_empty_r;
  assign out_full_flag  = out_full_r;

endmodule : positional_list_engine
`default_nettype wire

/* sim/tb_positional_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A directed opening
// walks the list through empty, full and every refusal. Random traffic
// follows: mostly in-range operations on a live list, with some clears,
// spare opcodes and out-of-range positions. A shadow list predicts every
// result, and the monitor compares them in order. Sender gaps and receiver
// stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

  localparam int CAPACITY   = 8;
  localparam int RandomReqs = 1550;
  localparam int PhaseCount = 8;
  localparam ple_pkg::op_t OpSpareFirst = 3'd5;
  localparam ple_pkg::op_t OpSpareLast  = 3'd7;

  typedef struct {
    ple_pkg::op_t   op;
    ple_pkg::pos_t  pos;
    ple_pkg::word_t value;
    bit             hold;
    int             send_pct;
    int             recv_pct;
  } list_request_t;

  typedef struct packed {
    ple_pkg::status_t           status;
    ple_pkg::word_t             read_value;
    logic [ple_pkg::TotalW-1:0] item_total;
    logic                       empty_flag;
    logic                       full_flag;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ple_pkg::op_t in_operation = '0;
  ple_pkg::pos_t in_position = '0;
  ple_pkg::word_t in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ple_pkg::status_t out_status;
  ple_pkg::word_t out_read_value;
  logic [ple_pkg::TotalW-1:0] out_item_total;
  logic out_empty_flag;
  logic out_full_flag;

  list_request_t request_queue[$];
  list_result_t pending_results[$];

  // shadow copy of the list
  ple_pkg::word_t shadow_words[CAPACITY];
  int shadow_count = 0;

  logic in_fire = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int spare_sent = 0;
  int results_checked = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  // stimulus-side phase settings and drain hold
  int gen_send_pct = 0;
  int gen_recv_pct = 0;
  bit gen_hold = 1'b0;

  positional_list_engine #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_item_total(out_item_total),
    .out_empty_flag(out_empty_flag),
    .out_full_flag(out_full_flag)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic list_result_t list_apply(ple_pkg::op_t op, ple_pkg::pos_t pos,
                                              ple_pkg::word_t val);
    list_result_t r;
    logic was_full;
    logic was_empty;
    int i;
    r = '0;
    r.status = ple_pkg::STATUS_OK;
    was_full = (shadow_count >= CAPACITY);
    was_empty = (shadow_count == 0);
    case (op)
      ple_pkg::OP_CLEAR: begin
        shadow_count = 0;
      end
      ple_pkg::OP_APPEND: begin
        if (was_full) begin
          r.status = ple_pkg::STATUS_FULL;
        end else begin
          shadow_words[shadow_count] = val;
          shadow_count++;
        end
      end
      ple_pkg::OP_INSERT: begin
        if (was_full) begin
          r.status = ple_pkg::STATUS_FULL;
        end else if (was_empty) begin
          r.status = ple_pkg::STATUS_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          r.status = ple_pkg::STATUS_RANGE;
        end else begin
          for (i = shadow_count; i > int'(pos); i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = val;
          shadow_count++;
        end
      end
      ple_pkg::OP_RETRIEVE, ple_pkg::OP_REPLACE: begin
        if (was_empty) begin
          r.status = ple_pkg::STATUS_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          r.status = ple_pkg::STATUS_RANGE;
        end else begin
          r.read_value = shadow_words[pos];
          if (op == ple_pkg::OP_REPLACE) shadow_words[pos] = val;
        end
      end
      default: begin
      end
    endcase
    r.item_total = shadow_count[ple_pkg::TotalW-1:0];
    r.empty_flag = (shadow_count == 0);
    r.full_flag = (shadow_count >= CAPACITY);
    return r;
  endfunction

  task automatic queue_op(ple_pkg::op_t op, ple_pkg::pos_t pos, ple_pkg::word_t val);
    list_request_t req;
    req.op = op;
    req.pos = pos;
    req.value = val;
    req.hold = gen_hold;
    req.send_pct = gen_send_pct;
    req.recv_pct = gen_recv_pct;
    gen_hold = 1'b0;
    request_queue.push_back(req);
  endtask

  // driver: one decision per falling edge
  always @(negedge clk) begin : drive_requests
    list_request_t req;
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      next_valid = in_valid && !in_fire;
      if (!next_valid && request_queue.size() != 0) begin
        if (!(request_queue[0].hold && pending_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          req = request_queue.pop_front();
          send_idle_pct = req.send_pct;
          recv_stall_pct = req.recv_pct;
          in_operation <= req.op;
          in_position <= req.pos;
          in_value <= req.value;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: results are checked before the new transaction's prediction is queued
  always @(posedge clk) begin : watch_channels
    list_result_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, read_value %0d, item_total %0d",
                 out_status, out_read_value, out_item_total);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          status_tally[out_status]++;
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, got %0d",
                   want.read_value, out_read_value);
            mismatch_count++;
          end
          if (out_item_total !== want.item_total) begin
            $error("item_total mismatch: expected %0d, got %0d",
                   want.item_total, out_item_total);
            mismatch_count++;
          end
          if (out_empty_flag !== want.empty_flag) begin
            $error("empty_flag mismatch: expected %0d, got %0d",
                   want.empty_flag, out_empty_flag);
            mismatch_count++;
          end
          if (out_full_flag !== want.full_flag) begin
            $error("full_flag mismatch: expected %0d, got %0d",
                   want.full_flag, out_full_flag);
            mismatch_count++;
          end
        end
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        pending_results.push_back(list_apply(in_operation, in_position, in_value));
        requests_sent++;
        if (in_operation >= OpSpareFirst) spare_sent++;
      end
    end
  end

  initial begin : run_test
    int gen_count;
    int made;
    int phase;
    int r;
    ple_pkg::op_t op;
    ple_pkg::pos_t pos;
    ple_pkg::word_t val;

    // directed opening: empty list, refusals, extremes, full list
    queue_op(ple_pkg::OP_CLEAR, 3'd0, 32'sd0);
    queue_op(ple_pkg::OP_RETRIEVE, 3'd0, 32'sd0);
    queue_op(ple_pkg::OP_REPLACE, 3'd7, 32'sd5);
    queue_op(ple_pkg::OP_INSERT, 3'd0, 32'sd9);
    queue_op(ple_pkg::OP_APPEND, 3'd0, 32'h8000_0000);
    queue_op(ple_pkg::OP_INSERT, 3'd1, 32'sd3);
    queue_op(ple_pkg::OP_INSERT, 3'd0, 32'h7FFF_FFFF);
    queue_op(ple_pkg::OP_APPEND, 3'd7, 32'sd0);
    queue_op(ple_pkg::OP_APPEND, 3'd0, -32'sd1);
    queue_op(ple_pkg::OP_APPEND, 3'd0, 32'h5555_5555);
    queue_op(ple_pkg::OP_APPEND, 3'd0, 32'hAAAA_AAAA);
    queue_op(ple_pkg::OP_INSERT, 3'd3, 32'sd1);
    queue_op(ple_pkg::OP_RETRIEVE, 3'd7, 32'sd0);
    queue_op(ple_pkg::OP_APPEND, 3'd0, 32'h0F0F_F0F0);
    queue_op(ple_pkg::OP_APPEND, 3'd0, 32'sd77);
    queue_op(ple_pkg::OP_INSERT, 3'd0, 32'sd78);
    queue_op(ple_pkg::OP_RETRIEVE, 3'd7, 32'sd0);
    queue_op(ple_pkg::OP_REPLACE, 3'd0, -32'sd2);
    queue_op(ple_pkg::OP_RETRIEVE, 3'd0, 32'sd0);
    queue_op(OpSpareFirst, 3'd2, 32'sd11);
    queue_op(OpSpareLast, 3'd5, -32'sd11);
    queue_op(ple_pkg::OP_CLEAR, 3'd0, 32'sd0);
    queue_op(ple_pkg::OP_REPLACE, 3'd0, 32'sd4);
    queue_op(ple_pkg::OP_APPEND, 3'd0, 32'sd42);
    queue_op(ple_pkg::OP_RETRIEVE, 3'd1, 32'sd0);
    queue_op(ple_pkg::OP_REPLACE, 3'd0, 32'sd43);

    // random traffic in phases: none, sender gaps, receiver stalls, both
    gen_count = 1;
    made = 0;
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0: begin gen_send_pct = 0;  gen_recv_pct = 0;  end
        1: begin gen_send_pct = 75; gen_recv_pct = 0;  end
        2: begin gen_send_pct = 0;  gen_recv_pct = 75; end
        default: begin gen_send_pct = 23; gen_recv_pct = 23; end
      endcase
      // let the engine drain completely before each new phase
      gen_hold = 1'b1;
      while (made < (RandomReqs * (phase + 1)) / PhaseCount) begin
        r = $urandom_range(99);
        if (r < 3 || (gen_count == CAPACITY && r < 15)) op = ple_pkg::OP_CLEAR;
        else if (r < 5) op = ple_pkg::op_t'($urandom_range(OpSpareLast, OpSpareFirst));
        else if (r < 32) op = ple_pkg::OP_APPEND;
        else if (r < 52) op = ple_pkg::OP_INSERT;
        else if (r < 76) op = ple_pkg::OP_RETRIEVE;
        else op = ple_pkg::OP_REPLACE;
        if (gen_count > 0 && $urandom_range(99) < 85)
          pos = ple_pkg::pos_t'($urandom_range(gen_count - 1));
        else
          pos = ple_pkg::pos_t'($urandom_range(ple_pkg::PosSpan - 1));
        case ($urandom_range(19))
          0: val = 32'h8000_0000;
          1: val = 32'h7FFF_FFFF;
          2: val = -32'sd1;
          3: val = 32'sd0;
          default: val = ple_pkg::word_t'($urandom);
        endcase
        queue_op(op, pos, val);
        case (op)
          ple_pkg::OP_CLEAR: gen_count = 0;
          ple_pkg::OP_APPEND: if (gen_count < CAPACITY) gen_count++;
          ple_pkg::OP_INSERT:
            if (gen_count > 0 && gen_count < CAPACITY && int'(pos) < gen_count)
              gen_count++;
          default: begin
          end
        endcase
        if (op <= ple_pkg::OP_REPLACE) made++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4 * (CAPACITY + 2)) @(posedge clk);

    $display("summary: %0d transactions sent (%0d with spare opcodes), %0d results checked",
             requests_sent, spare_sent, results_checked);
    $display("summary: statuses ok %0d, full %0d, empty %0d, out of range %0d",
             status_tally[ple_pkg::STATUS_OK], status_tally[ple_pkg::STATUS_FULL],
             status_tally[ple_pkg::STATUS_EMPTY], status_tally[ple_pkg::STATUS_RANGE]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d results still outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

/* positional_list_engine.f */
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
sim/tb_positional_list_engine.sv
